// File: rtl/sbp_pkg.sv
// Shared types, packet codes and the digit helper for the scoreboard packet parser.
// Used by every module of the block; depends on nothing.
package sbp_pkg;

    // Packet framing and type codes
    localparam logic [7:0] SOP_BYTE       = 8'h0A;
    localparam logic [7:0] TYPE_HOME      = 8'h00;
    localparam logic [7:0] TYPE_PERIOD    = 8'h02;
    localparam logic [7:0] TYPE_AWAY      = 8'h03;
    localparam logic [7:0] TYPE_STARTSTOP = 8'h30;
    localparam logic [7:0] TYPE_TIME      = 8'h0C;
    localparam logic [7:0] TYPE_SUBMIN    = 8'h41;
    localparam logic [7:0] TYPE_SHOT      = 8'h12;
    localparam logic [7:0] CLK_START      = 8'h20;
    localparam logic [7:0] CLK_STOP       = 8'h40;
    localparam logic [7:0] SUBMIN_ON      = 8'h4E;
    localparam logic [3:0] BLANK_NIBBLE   = 4'hF;

    localparam int TIME_SLOTS = 4;
    localparam int PAIR_SLOTS = 2;

    typedef enum logic [9:0] {
        PH_END       = 10'b00_0000_0001,
        PH_ADDR      = 10'b00_0000_0010,
        PH_STARTSTOP = 10'b00_0000_0100,
        PH_TIME      = 10'b00_0000_1000,
        PH_HOME      = 10'b00_0001_0000,
        PH_AWAY      = 10'b00_0010_0000,
        PH_PERIOD    = 10'b00_0100_0000,
        PH_SUBMIN    = 10'b00_1000_0000,
        PH_SHOT      = 10'b01_0000_0000,
        PH_UNKNOWN   = 10'b10_0000_0000
    } phase_t;

    typedef logic [6:0] slot_t;

    typedef struct packed {
        slot_t [TIME_SLOTS-1:0] time_d;
        slot_t [PAIR_SLOTS-1:0] home_d;
        slot_t [PAIR_SLOTS-1:0] away_d;
        slot_t [PAIR_SLOTS-1:0] shot_d;
        logic [6:0]             period;
        logic                   running;
        logic                   last_min;
    } store_t;

    // Parser output: stored packet data for the decoder plus the emit strobe for the output buffer
    typedef struct packed {
        logic   fire;
        store_t data;
    } parse_out_t;

    typedef struct packed {
        logic [8:0] home_score;
        logic [8:0] guest_score;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [6:0] period;
        logic [7:0] shot_clock;
        logic       clock_running;
        logic       under_one_minute;
    } result_t;

    // Blank display digit reads as zero
    function automatic logic [3:0] digit_val(input logic [3:0] n);
        digit_val = (n == BLANK_NIBBLE) ? 4'd0 : n;
    endfunction

endpackage

// File: rtl/scoreboard_serial_packet_parser_core.sv
// Scoreboard serial packet parser, top level. Depends on sbp_pkg and its submodules.
// Throughput: one byte per cycle while rx_ready is high; each byte is parsed in the cycle
// it is accepted. The closing byte of a game-time packet pushes its item into the output
// register, or its skid entry if the output register is occupied; it is held until taken.
// rx_ready drops only when both the output register and its skid entry are full.
// Reset (rst_n low, asynchronous): parser at end of packet, stored data zero, output empty.
module scoreboard_serial_packet_parser_core
    import sbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [8:0] home_score,
    output logic [8:0] guest_score,
    output logic [7:0] minutes,
    output logic [7:0] seconds,
    output logic [6:0] period,
    output logic [7:0] shot_clock,
    output logic       clock_running,
    output logic       under_one_minute
);

    logic       take;
    logic       space;
    parse_out_t po;
    result_t    dec_res;
    result_t    out_res;

    assign rx_ready = space;
    assign take     = rx_valid && space;

    sbp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .po      (po)
    );

    sbp_decode u_decode (
        .data (po.data),
        .res  (dec_res)
    );

    sbp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (po.fire),
        .push_data (dec_res),
        .space     (space),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (out_res)
    );

    assign home_score       = out_res.home_score;
    assign guest_score      = out_res.guest_score;
    assign minutes          = out_res.minutes;
    assign seconds          = out_res.seconds;
    assign period           = out_res.period;
    assign shot_clock       = out_res.shot_clock;
    assign clock_running    = out_res.clock_running;
    assign under_one_minute = out_res.under_one_minute;

endmodule

// File: rtl/sbp_parser.sv
// Byte-level packet state machine and per-type data store.
// Depends on sbp_pkg.
module sbp_parser
    import sbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    output parse_out_t po
);

    phase_t     phase_reg, phase_next;
    logic [2:0] count_reg, count_next;
    store_t     store_reg, store_next;
    logic       fire;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        store_next = store_reg;
        fire       = 1'b0;
        if (take)
        begin
            if (phase_reg != PH_END && rx_byte[7])
            begin
                // close the packet; only a game-time packet yields an item
                fire       = (phase_reg == PH_TIME);
                phase_next = PH_END;
                count_next = 3'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_END:
                    begin
                        if (rx_byte == SOP_BYTE)
                            phase_next = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        if (rx_byte == TYPE_HOME)
                            phase_next = PH_HOME;
                        else if (rx_byte == TYPE_PERIOD)
                            phase_next = PH_PERIOD;
                        else if (rx_byte == TYPE_AWAY)
                            phase_next = PH_AWAY;
                        else if (rx_byte == TYPE_STARTSTOP)
                            phase_next = PH_STARTSTOP;
                        else if (rx_byte == TYPE_TIME)
                            phase_next = PH_TIME;
                        else if (rx_byte == TYPE_SUBMIN)
                            phase_next = PH_SUBMIN;
                        else if (rx_byte == TYPE_SHOT)
                            phase_next = PH_SHOT;
                        else
                            phase_next = PH_UNKNOWN;
                    end
                    PH_PERIOD:
                    begin
                        store_next.period = rx_byte[6:0];
                    end
                    PH_SHOT:
                    begin
                        if (count_reg < 3'(PAIR_SLOTS))
                        begin
                            store_next.shot_d[count_reg[0]] = rx_byte[6:0];
                            count_next = count_reg + 3'd1;
                        end
                    end
                    PH_HOME:
                    begin
                        if (count_reg < 3'(PAIR_SLOTS))
                        begin
                            store_next.home_d[count_reg[0]] = rx_byte[6:0];
                            count_next = count_reg + 3'd1;
                        end
                    end
                    PH_AWAY:
                    begin
                        if (count_reg < 3'(PAIR_SLOTS))
                        begin
                            store_next.away_d[count_reg[0]] = rx_byte[6:0];
                            count_next = count_reg + 3'd1;
                        end
                    end
                    PH_TIME:
                    begin
                        if (count_reg < 3'(TIME_SLOTS))
                        begin
                            store_next.time_d[count_reg[1:0]] = rx_byte[6:0];
                            count_next = count_reg + 3'd1;
                        end
                    end
                    PH_STARTSTOP:
                    begin
                        if (rx_byte == CLK_START)
                            store_next.running = 1'b1;
                        if (rx_byte == CLK_STOP)
                            store_next.running = 1'b0;
                    end
                    PH_SUBMIN:
                    begin
                        // drop the flag byte while the clock is stopped
                        if (store_reg.running)
                            store_next.last_min = (rx_byte == SUBMIN_ON);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_END;
            count_reg <= 3'd0;
            store_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            store_reg <= store_next;
        end
    end

    // store is unchanged by a closing byte, so the registered copy is current
    assign po.fire = fire;
    assign po.data = store_reg;

endmodule

// File: rtl/sbp_decode.sv
// Converts stored digit bytes into binary score, clock and status values.
// Depends on sbp_pkg.
module sbp_decode
    import sbp_pkg::*;
(
    input  store_t  data,
    output result_t res
);

    function automatic logic [7:0] two_digits(input slot_t hi, input slot_t lo);
        two_digits = 8'(digit_val(hi[3:0])) * 8'd10 + 8'(digit_val(lo[3:0]));
    endfunction

    // hundreds in bits 6:5; the units nibble is taken raw, blank included
    function automatic logic [8:0] score(input slot_t hi, input slot_t lo);
        score = 9'(hi[6:5]) * 9'd100 + 9'(digit_val(hi[3:0])) * 9'd10 + 9'(lo[3:0]);
    endfunction

    always_comb
    begin
        res.home_score       = score(data.home_d[0], data.home_d[1]);
        res.guest_score      = score(data.away_d[0], data.away_d[1]);
        res.minutes          = two_digits(data.time_d[0], data.time_d[1]);
        res.seconds          = two_digits(data.time_d[2], data.time_d[3]);
        res.period           = data.period;
        res.shot_clock       = two_digits(data.shot_d[0], data.shot_d[1]);
        res.clock_running    = data.running;
        res.under_one_minute = data.last_min;
    end

endmodule

// File: rtl/sbp_outbuf.sv
// Output register with one skid entry; ready toward the input comes from a register.
// Depends on sbp_pkg.
module sbp_outbuf
    import sbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                // advance the skid entry; no push can arrive while it is full
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
